/* rtl/silu_pkg.sv */
// Shared types, constants and the sigmoid table generator for the SiLU core.
`timescale 1ns / 1ps

package silu_pkg;

	// Sample format and table geometry
	localparam int DATA_WIDTH   = 16;
	localparam int SEGMENTS_DEF = 64;
	localparam int SIG_W        = 17;             // sigmoid, unsigned Q1.16, up to 1.0
	localparam int FRAC_W       = 15;             // segment fraction bits
	localparam int Q_SHIFT      = 16;             // Q1.16 product scaling
	localparam int TAYLOR_TERMS = 20;

	localparam logic [63:0]      EXP_ONE  = 64'd1 << 30;
	localparam logic [SIG_W-1:0] FRAC_ONE = SIG_W'(1) << Q_SHIFT;

	// Request payload
	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] x_in;
		logic                         last_in;
	} sample_t;

	// Result payload
	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] y_out;
		logic                         last_out;
	} result_t;

	// Sample control travelling from the sigmoid stages to the multiplier
	typedef struct packed {
		logic                         valid;
		logic                         last;
		logic signed [DATA_WIDTH-1:0] x;
	} stage_t;

	// exp(-num/Den) in Q2.30 by truncated series, for num <= Den
	function automatic logic [63:0] exp_neg_frac(input logic [63:0] num,
			input logic [63:0] Den);
		logic [63:0] sum;
		logic [63:0] term;
		logic [63:0] Div;
		sum  = EXP_ONE;
		term = EXP_ONE;
		for (int n = 1; n <= TAYLOR_TERMS; n++) begin
			Div  = Den * 64'(n);
			term = (term * num) / Div;
			if (n[0])
				sum = sum - term;
			else
				sum = sum + term;
		end
		return sum;
	endfunction

	// Sigmoid at breakpoint 8*K/Segs, unsigned Q1.16; evaluated at elaboration only
	function automatic logic [SIG_W-1:0] sig_entry(input int unsigned K,
			input int unsigned Segs);
		logic [63:0] e1;
		logic [63:0] e;
		logic [63:0] whole;
		logic [63:0] rest;
		logic [63:0] Dd;
		e1    = exp_neg_frac(64'd1, 64'd1);
		whole = (64'(K) * 64'd8) / 64'(Segs);
		rest  = (64'(K) * 64'd8) % 64'(Segs);
		e     = exp_neg_frac(rest, 64'(Segs));
		for (int j = 0; j < 8; j++) begin
			if (64'(j) < whole)
				e = (e * e1 + (64'd1 << 29)) >> 30;
		end
		Dd = EXP_ONE + e;
		return SIG_W'(((64'd1 << 46) + (Dd >> 1)) / Dd);
	endfunction

endpackage

/* rtl/silu_sig_lut.sv */
// Sigmoid stages: magnitude, segment index, table read, interpolation, sign fold.
`timescale 1ns / 1ps

module silu_sig_lut #(
	parameter int SEGMENTS = silu_pkg::SEGMENTS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  silu_pkg::sample_t           sample,
	output silu_pkg::stage_t            ctl,
	output logic [silu_pkg::SIG_W-1:0]  sig
);

	localparam int DW  = silu_pkg::DATA_WIDTH;
	localparam int SW  = silu_pkg::SIG_W;
	localparam int FW  = silu_pkg::FRAC_W;
	localparam int AW  = $clog2(SEGMENTS + 1);
	localparam int PW  = FW + AW;
	localparam int MW  = SW + FW;

	// Constant breakpoint table, SEGMENTS+1 entries
	logic [SW-1:0] tab [SEGMENTS+1];

	for (genvar k = 0; k <= SEGMENTS; k++) begin : g_tab
		localparam logic [SW-1:0] ENTRY = silu_pkg::sig_entry(k, SEGMENTS);
		assign tab[k] = ENTRY;
	end

	// Valid bits
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;

	// Carried sample
	logic                 last_s1, last_s2, last_s3, last_s4, last_s5;
	logic signed [DW-1:0] x_s1, x_s2, x_s3, x_s4, x_s5;

	// Datapath
	logic [FW-1:0] a_s1;
	logic          big_s1, big_s2, big_s3, big_s4;
	logic [AW-1:0] idx_s2;
	logic [FW-1:0] f_s2, f_s3;
	logic [SW-1:0] lo_s3, hi_s3, lo_s4;
	logic [MW-1:0] mul_s4;
	logic [SW-1:0] sig_s5;

	logic [DW-1:0] a_abs;
	logic [PW-1:0] p_pos;
	logic [AW-1:0] idx_hi;
	logic [SW-1:0] diff;
	logic [MW:0]   mul_rnd;
	logic [SW-1:0] s_mag;
	logic [SW-1:0] s_fold;

	assign a_abs  = sample.x_in[DW-1] ? DW'(-sample.x_in) : DW'(sample.x_in);
	assign p_pos  = PW'(a_s1) * PW'(SEGMENTS);
	assign idx_hi = idx_s2 + AW'(1);
	assign diff   = hi_s3 - lo_s3;
	assign mul_rnd = (MW+1)'(mul_s4) + ((MW+1)'(1) << (FW - 1));

	// Interpolated magnitude, then fold for negative samples
	always_comb begin
		s_mag = lo_s4 + SW'(mul_rnd[MW:FW]);
		if (big_s4)
			s_mag = silu_pkg::FRAC_ONE;
		if (x_s4[DW-1])
			s_fold = silu_pkg::FRAC_ONE - s_mag;
		else
			s_fold = s_mag;
	end

	// Valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	// Payload stages
	always_ff @(posedge clk) begin
		// s1: magnitude; only the most negative sample reaches 8.0
		x_s1    <= sample.x_in;
		last_s1 <= sample.last_in;
		a_s1    <= a_abs[FW-1:0];
		big_s1  <= a_abs[DW-1];
		// s2: segment index and fraction
		x_s2    <= x_s1;
		last_s2 <= last_s1;
		big_s2  <= big_s1;
		idx_s2  <= p_pos[PW-1:FW];
		f_s2    <= p_pos[FW-1:0];
		// s3: table read at both ends of the segment
		x_s3    <= x_s2;
		last_s3 <= last_s2;
		big_s3  <= big_s2;
		lo_s3   <= tab[idx_s2];
		hi_s3   <= tab[idx_hi];
		f_s3    <= f_s2;
		// s4: slope times fraction
		x_s4    <= x_s3;
		last_s4 <= last_s3;
		big_s4  <= big_s3;
		lo_s4   <= lo_s3;
		mul_s4  <= MW'(diff) * MW'(f_s3);
		// s5: rounded sigmoid
		x_s5    <= x_s4;
		last_s5 <= last_s4;
		sig_s5  <= s_fold;
	end

	assign ctl.valid = valid_s5;
	assign ctl.last  = last_s5;
	assign ctl.x     = x_s5;
	assign sig       = sig_s5;

endmodule

/* rtl/silu_mult.sv */
// Output stages: sample times sigmoid, round half up, saturate, result register.
`timescale 1ns / 1ps

module silu_mult (
	input  logic                        clk,
	input  logic                        arst_n,
	input  silu_pkg::stage_t            ctl,
	input  logic [silu_pkg::SIG_W-1:0]  sig,
	output logic                        done,
	output silu_pkg::result_t           result
);

	localparam int DW = silu_pkg::DATA_WIDTH;
	localparam int SW = silu_pkg::SIG_W;
	localparam int QS = silu_pkg::Q_SHIFT;
	localparam int PW = DW + SW + 1;
	localparam int YW = PW - QS;

	localparam logic signed [YW-1:0] Y_MAX = YW'((64'd1 << (DW - 1)) - 64'd1);
	localparam logic signed [YW-1:0] Y_MIN = -Y_MAX - YW'(1);

	logic                 valid_s6, valid_s7;
	logic                 last_s6, last_s7;
	logic signed [PW-1:0] prod_s6;
	logic signed [DW-1:0] y_s7;

	logic signed [PW-1:0] prod;
	logic signed [YW-1:0] y_wide;
	logic signed [DW-1:0] y_sat;

	// Product with the rounding half already added
	assign prod = PW'(ctl.x) * PW'($signed({1'b0, sig}))
			+ (PW'(1) <<< (QS - 1));

	// Floor shift, then clamp
	always_comb begin
		y_wide = prod_s6[PW-1:QS];
		if (y_wide > Y_MAX)
			y_sat = DW'(Y_MAX);
		else if (y_wide < Y_MIN)
			y_sat = DW'(Y_MIN);
		else
			y_sat = y_wide[DW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
		end else begin
			valid_s6 <= ctl.valid;
			valid_s7 <= valid_s6;
		end
	end

	always_ff @(posedge clk) begin
		prod_s6 <= prod;
		last_s6 <= ctl.last;
		y_s7    <= y_sat;
		last_s7 <= last_s6;
	end

	assign done            = valid_s7;
	assign result.y_out    = y_s7;
	assign result.last_out = last_s7;

endmodule

/* rtl/silu_activation_core.sv */
// Top level of the SiLU activation core: request port, pipeline, result port.
`timescale 1ns / 1ps

// SiLU core: y = x * sigmoid(x) on signed Q4.12 samples, rounded half up and
// saturated. A request is taken whenever start is high; busy is always low, so
// one sample enters every cycle. Each result appears on result for exactly one
// cycle with done high, in request order; the receiver cannot stall, so it must
// take every result as it comes. The pipeline has seven register stages:
// magnitude, segment index (constant multiply), table read, slope multiply,
// sigmoid fold, product multiply and the output register. Sigmoid is
// interpolated from a constant table of SEGMENTS+1 breakpoints over |x| in
// [0, 8), built at elaboration; last_in is carried through unchanged to
// last_out.

module silu_activation_core #(
	parameter int SEGMENTS = silu_pkg::SEGMENTS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  silu_pkg::sample_t sample,
	output logic              done,
	output silu_pkg::result_t result
);

	localparam int LATENCY = 7;
	localparam int DW      = silu_pkg::DATA_WIDTH;

	silu_pkg::stage_t             ctl;
	logic [silu_pkg::SIG_W-1:0]   sig;
	logic                         accept;

	// Fully pipelined, never holds a request off
	assign busy   = 1'b0;
	assign accept = start && !busy;

	silu_sig_lut #(
		.SEGMENTS (SEGMENTS)
	) u_lut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (accept),
		.sample   (sample),
		.ctl      (ctl),
		.sig      (sig)
	);

	silu_mult u_mult (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.sig    (sig),
		.done   (done),
		.result (result)
	);

	// Every result traces back to a request a fixed latency earlier
	a_done_origin: assert property (@(posedge clk) disable iff (!arst_n)
			done |-> $past(accept, LATENCY))
		else $error("result without a matching request");

	// The last flag stays aligned with its sample
	a_last_align: assert property (@(posedge clk) disable iff (!arst_n)
			done |-> result.last_out == $past(sample.last_in, LATENCY))
		else $error("last flag out of step with its sample");

	// A non-zero result carries the sign of its sample
	a_sign: assert property (@(posedge clk) disable iff (!arst_n)
			(done && result.y_out != '0) |->
			result.y_out[DW-1] == $past(sample.x_in[DW-1], LATENCY))
		else $error("result sign differs from sample sign");

endmodule
